@@ src/gso_pkg.sv @@
// Shared types, constants and a saturation helper function for the Gram-Schmidt orthonormaliser.
package gso_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLUMNS = 16;

  localparam int RESW      = 40;  // residual width, Q16.16 with headroom
  localparam int ACCW      = 56;  // dot product accumulator width
  localparam int PRODW     = 65;  // widest product (33 x 32 bits)
  localparam int DVDW      = 62;  // divider dividend and quotient width
  localparam int DIV_STEPS = 62;

  localparam logic [1:0] REG_ROWS      = 2'd0;
  localparam logic [1:0] REG_COLUMNS   = 2'd1;
  localparam logic [1:0] REG_FIRST_THR = 2'd2;
  localparam logic [1:0] REG_LATER_THR = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DOT_RD,
    S_DOT_MUL,
    S_DOT_ACC,
    S_DOT_PS,
    S_SUB_RD,
    S_SUB_MUL,
    S_SUB_WR,
    S_NRM_RD,
    S_NRM_CLAMP,
    S_NRM_MUL,
    S_NRM_ACC,
    S_SQRT,
    S_THR,
    S_OUT_RD,
    S_OUT_CALC,
    S_OUT_DIV,
    S_OUT_EMIT
  } gso_state_t;

  // Saturates a signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

@@ src/gso_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the normalisation step.
module gso_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [gso_pkg::DVDW-1:0] dividend,
  input  logic [31:0]              divisor,
  output logic                     done,
  output logic [gso_pkg::DVDW-1:0] quotient
);
  import gso_pkg::*;

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic [DVDW-1:0] dvd_r, dvd_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [33:0]     rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, dvd_r[DVDW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(DIV_STEPS - 1);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The quotient bits shift into the dividend register from below.
      if (rem_sh >= {2'b00, divisor}) begin
        rem_nxt = 33'(rem_sh - {2'b00, divisor});
        dvd_nxt = {dvd_r[DVDW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[32:0];
        dvd_nxt = {dvd_r[DVDW-2:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

@@ src/gram_schmidt_orthonormalizer_top.sv @@
// Top level of the Gram-Schmidt orthonormaliser: sequencer, working memories and output register.
//
//   channel  direction  ports                       word contents
//   in_      slave      tvalid tready tdata         one matrix element, column-major
//   out_     master     tvalid tready tdata tlast   one orthonormalised element
//                       tuser
//   cfg_     write      we addr wdata               register writes, no read-back
//
// Elements of a column are taken one per cycle while the sequencer is idle. On the last row
// of column j (N rows) the sequencer makes j passes (a dot product of read, multiply and
// accumulate per row, then a subtraction of read, multiply and write per row), a norm sum,
// a bitwise square root and, when normalising, a divide for each element.
// Reset is synchronous; the memories are not cleared. A stalled output holds the sequencer
// in its emit state, and input is taken only while the sequencer is idle.
module gram_schmidt_orthonormalizer_top #(
  parameter int MAX_ROWS    = gso_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = gso_pkg::DEF_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] element_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic        out_tlast,  // column_end
  output logic [1:0]  out_tuser,  // [0] norm_too_small, [1] matrix_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import gso_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WKW   = 32 + RESW;

  // Configuration registers.
  logic [4:0]  rows_cfg_r, cols_cfg_r;
  logic [31:0] first_thr_r, later_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r  <= 5'd16;
      cols_cfg_r  <= 5'd16;
      first_thr_r <= 32'd1;
      later_thr_r <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS:      rows_cfg_r  <= cfg_wdata[4:0];
        REG_COLUMNS:   cols_cfg_r  <= cfg_wdata[4:0];
        REG_FIRST_THR: first_thr_r <= cfg_wdata;
        REG_LATER_THR: later_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [RW-1:0] nrows_m1;
  logic [CW-1:0] ncols_m1;

  always_comb begin
    if (rows_cfg_r == 5'd0) begin
      nrows_m1 = '0;
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      nrows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      nrows_m1 = RW'(rows_cfg_r - 5'd1);
    end
    if (cols_cfg_r == 5'd0) begin
      ncols_m1 = '0;
    end else if (32'(cols_cfg_r) > MAX_COLUMNS) begin
      ncols_m1 = CW'(MAX_COLUMNS - 1);
    end else begin
      ncols_m1 = CW'(cols_cfg_r - 5'd1);
    end
  end

  // Sequencer registers.
  gso_state_t state_r, state_nxt;
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] col_cnt_r;
  logic [CW-1:0] col_r;
  logic [CW-1:0] k_r;
  logic [RW-1:0] i_r;
  logic          last_col_r;
  logic          small_r;

  // Datapath registers.
  logic signed [ACCW-1:0]  acc_r;
  logic signed [32:0]      ps_r;
  logic signed [PRODW-1:0] prod_r;
  logic [63:0]             sumsq_r;
  logic [63:0]             sq_v_r, sq_res_r, sq_bit_r;
  logic signed [31:0]      r_r;
  logic signed [31:0]      val_r;

  // Memories and their read data.
  logic [31:0]    bs_mem [DEPTH];
  logic [WKW-1:0] wk_mem [MAX_ROWS];
  logic [31:0]    bs_rd_r;
  logic [WKW-1:0] wk_rd_r;

  logic           in_acc;
  logic [RW-1:0]  in_idx;
  logic           out_free;
  logic           bs_re, bs_we, wk_re, wk_we;
  logic [AW-1:0]  bs_raddr, bs_waddr;
  logic [RW-1:0]  wk_waddr;
  logic [WKW-1:0] wk_wdata;

  logic signed [31:0]     q_s, x_s;
  logic signed [RESW-1:0] resid_s, resid_new;
  logic signed [63:0]     mul_qx, mul_rr;
  logic signed [PRODW-1:0] mul_pq;
  logic signed [ACCW-1:0] acc_sh;
  logic [64:0]            sumsq_add;
  logic [63:0]            sq_try;
  logic signed [31:0]     r_clamp;
  logic [31:0]            r_mag;
  logic                   dv_start, dv_done;
  logic [DVDW-1:0]        dv_quot;
  logic signed [31:0]     q_val;
  logic [31:0]            thr;

  assign in_acc   = in_tvalid && in_tready;
  assign in_idx   = (row_cnt_r >= nrows_m1) ? nrows_m1 : row_cnt_r;
  assign out_free = !out_tvalid || out_tready;

  assign q_s       = bs_rd_r;
  assign x_s       = wk_rd_r[WKW-1:RESW];
  assign resid_s   = wk_rd_r[RESW-1:0];
  assign mul_qx    = q_s * x_s;
  assign mul_pq    = ps_r * q_s;
  assign mul_rr    = r_r * r_r;
  assign resid_new = resid_s - RESW'(prod_r >>> 30);
  assign acc_sh    = acc_r >>> 16;
  assign sumsq_add = {1'b0, sumsq_r} + {1'b0, prod_r[63:0]};
  assign sq_try    = sq_res_r + sq_bit_r;
  assign r_clamp   = sat32(64'(resid_s));
  // The divider is started in the same cycle as r_r is loaded, so it takes the clamped value.
  assign r_mag     = r_clamp[31] ? 32'(-r_clamp) : r_clamp;
  assign thr       = (col_r == '0) ? first_thr_r : later_thr_r;

  always_comb begin
    if (r_r[31]) begin
      q_val = (dv_quot > DVDW'(64'h80000000)) ? 32'sh80000000 : 32'(-dv_quot[31:0]);
    end else begin
      q_val = (dv_quot > DVDW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : dv_quot[31:0];
    end
  end

  gso_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend ({r_mag, 30'd0}),
    .divisor  (sq_res_r[31:0]),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_idx == nrows_m1) begin
          state_nxt = (((col_cnt_r >= ncols_m1) ? ncols_m1 : col_cnt_r) == '0) ?
                      S_NRM_RD : S_DOT_RD;
        end
      end
      S_DOT_RD:  state_nxt = S_DOT_MUL;
      S_DOT_MUL: state_nxt = S_DOT_ACC;
      S_DOT_ACC: state_nxt = (i_r == nrows_m1) ? S_DOT_PS : S_DOT_RD;
      S_DOT_PS:  state_nxt = S_SUB_RD;
      S_SUB_RD:  state_nxt = S_SUB_MUL;
      S_SUB_MUL: state_nxt = S_SUB_WR;
      S_SUB_WR: begin
        if (i_r != nrows_m1) begin
          state_nxt = S_SUB_RD;
        end else if (k_r == col_r - CW'(1)) begin
          state_nxt = S_NRM_RD;
        end else begin
          state_nxt = S_DOT_RD;
        end
      end
      S_NRM_RD:    state_nxt = S_NRM_CLAMP;
      S_NRM_CLAMP: state_nxt = S_NRM_MUL;
      S_NRM_MUL:   state_nxt = S_NRM_ACC;
      S_NRM_ACC:   state_nxt = (i_r == nrows_m1) ? S_SQRT : S_NRM_RD;
      S_SQRT:      state_nxt = (sq_bit_r == 64'd1) ? S_THR : S_SQRT;
      S_THR:       state_nxt = S_OUT_RD;
      S_OUT_RD:    state_nxt = S_OUT_CALC;
      S_OUT_CALC:  state_nxt = small_r ? S_OUT_EMIT : S_OUT_DIV;
      S_OUT_DIV:   state_nxt = dv_done ? S_OUT_EMIT : S_OUT_DIV;
      S_OUT_EMIT: begin
        if (out_free) begin
          state_nxt = (i_r == nrows_m1) ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_tready = (state_r == S_IDLE);
    bs_re     = (state_r == S_DOT_RD) || (state_r == S_SUB_RD);
    wk_re     = bs_re || (state_r == S_NRM_RD) || (state_r == S_OUT_RD);
    bs_we     = (state_r == S_OUT_EMIT) && out_free;
    bs_raddr  = AW'(k_r) * AW'(MAX_ROWS) + AW'(i_r);
    bs_waddr  = AW'(col_r) * AW'(MAX_ROWS) + AW'(i_r);
    dv_start  = (state_r == S_OUT_CALC) && !small_r;
    wk_we     = 1'b0;
    wk_waddr  = i_r;
    wk_wdata  = {x_s, resid_new};
    if (state_r == S_IDLE && in_acc) begin
      wk_we    = 1'b1;
      wk_waddr = in_idx;
      wk_wdata = {in_tdata, RESW'($signed(in_tdata))};
    end else if (state_r == S_SUB_WR) begin
      wk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bs_we) begin
      bs_mem[bs_waddr] <= val_r;
    end
    if (bs_re) begin
      bs_rd_r <= bs_mem[bs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_mem[wk_waddr] <= wk_wdata;
    end
    if (wk_re) begin
      wk_rd_r <= wk_mem[i_r];
    end
  end

  // Sequencer counters and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      col_r      <= '0;
      k_r        <= '0;
      i_r        <= '0;
      last_col_r <= 1'b0;
      small_r    <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Outside the emit state a taken word empties the output register.
      if (out_tready && state_r != S_OUT_EMIT) begin
        out_tvalid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_idx == nrows_m1) begin
              row_cnt_r  <= '0;
              col_r      <= (col_cnt_r >= ncols_m1) ? ncols_m1 : col_cnt_r;
              last_col_r <= (col_cnt_r >= ncols_m1);
              col_cnt_r  <= (col_cnt_r >= ncols_m1) ? '0 : col_cnt_r + CW'(1);
              k_r        <= '0;
              i_r        <= '0;
            end else begin
              row_cnt_r <= in_idx + RW'(1);
            end
          end
        end
        S_DOT_ACC: i_r <= (i_r == nrows_m1) ? '0 : i_r + RW'(1);
        S_SUB_WR: begin
          if (i_r == nrows_m1) begin
            i_r <= '0;
            k_r <= k_r + CW'(1);
          end else begin
            i_r <= i_r + RW'(1);
          end
        end
        S_NRM_ACC: i_r <= (i_r == nrows_m1) ? '0 : i_r + RW'(1);
        S_THR:     small_r <= !(sq_res_r[31:0] > thr);
        S_OUT_EMIT: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            i_r        <= (i_r == nrows_m1) ? '0 : i_r + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        acc_r   <= '0;
        sumsq_r <= '0;
      end
      S_DOT_MUL: prod_r <= PRODW'(mul_qx);
      S_DOT_ACC: acc_r  <= acc_r + ACCW'(prod_r >>> 14);
      S_DOT_PS: begin
        if (acc_sh > ACCW'(64'sd4294967295)) begin
          ps_r <= 33'sd4294967295;
        end else if (acc_sh < ACCW'(-64'sd4294967295)) begin
          ps_r <= -33'sd4294967295;
        end else begin
          ps_r <= acc_sh[32:0];
        end
        acc_r <= '0;
      end
      S_SUB_MUL:   prod_r <= mul_pq;
      S_NRM_CLAMP: r_r    <= r_clamp;
      S_NRM_MUL:   prod_r <= PRODW'(mul_rr);
      S_NRM_ACC: begin
        sumsq_r <= sumsq_add[64] ? '1 : sumsq_add[63:0];
        if (i_r == nrows_m1) begin
          sq_v_r   <= sumsq_add[64] ? '1 : sumsq_add[63:0];
          sq_res_r <= '0;
          sq_bit_r <= 64'h4000000000000000;
        end
      end
      S_SQRT: begin
        // One result bit per cycle; the root ends up in sq_res_r.
        if (sq_v_r >= sq_try) begin
          sq_v_r   <= sq_v_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_OUT_CALC: begin
        r_r   <= r_clamp;
        val_r <= sat32(64'(r_clamp) <<< 14);
      end
      S_OUT_DIV: begin
        if (dv_done) begin
          val_r <= q_val;
        end
      end
      S_OUT_EMIT: begin
        if (out_free) begin
          out_tdata    <= val_r;
          out_tuser[0] <= small_r;
          out_tlast    <= (i_r == nrows_m1);
          out_tuser[1] <= (i_r == nrows_m1) && last_col_r;
        end
      end
      default: ;
    endcase
  end

  a_in_mid_column: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_idx != nrows_m1) |=> (state_r == S_IDLE))
    else $error("sequencer left idle before the column was complete");

  a_store_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    bs_we |=> out_tvalid)
    else $error("basis written without a result word being presented");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == S_OUT_DIV))
    else $error("divider finished outside the divide state");

  a_matrix_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("matrix end flagged on a word that does not end a column");

endmodule
